FILE: hdl/mwm_pkg.sv
// Shared constants and types for the mecanum wheel mixer.
package mwm_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADBAND  = 2'd0,
    CFG_TURN_GAIN = 2'd1
  } cfg_idx_t;

  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned DEADBAND_W  = 7;
  localparam int unsigned TURN_GAIN_W = 12;

  localparam logic [DEADBAND_W-1:0]  DEADBAND_RST  = 7'd10;
  localparam logic [TURN_GAIN_W-1:0] TURN_GAIN_RST = 12'd256;

  // Axis and wheel arithmetic.
  localparam int unsigned AXIS_W  = 8;   // centred axis, signed, +-127
  localparam int unsigned SUM_W   = 9;   // sum of two axes, signed
  localparam int unsigned PROD_W  = 26;  // sum times 1/sqrt2 in Q.16
  localparam int unsigned ROT_W   = 18;  // rotated term in Q.8
  localparam int unsigned TURN_W  = 21;  // turn term in Q.8
  localparam int unsigned WHEEL_W = 22;  // wheel sum in Q.8

  localparam logic signed [PROD_W-1:0]  INV_SQRT2_Q16  = 26'sd46341;
  localparam logic signed [WHEEL_W-1:0] WHEEL_LIMIT_Q8 = 22'sd32512;

endpackage

FILE: hdl/mwm_axis.sv
// Centres one joystick byte, applies the deadband and clamps to +-127.
module mwm_axis (
  input  logic [7:0]                          raw,
  input  logic                                invert,
  input  logic [mwm_pkg::DEADBAND_W-1:0]      deadband,
  output logic signed [mwm_pkg::AXIS_W-1:0]   value
);

  logic [8:0]        zone_lo;
  logic [8:0]        zone_hi;
  logic              in_zone;
  logic signed [8:0] centred;

  // The dead zone is the open interval around the centre byte.
  assign zone_lo = 9'd127 - {2'b00, deadband};
  assign zone_hi = 9'd127 + {2'b00, deadband};
  assign in_zone = ({1'b0, raw} > zone_lo) && ({1'b0, raw} < zone_hi);

  // Inverted axes read 127 - b, the others b - 127.
  assign centred = invert ? (9'sd127 - $signed({1'b0, raw}))
                          : ($signed({1'b0, raw}) - 9'sd127);

  // Zero inside the dead zone, otherwise clamp the edge values.
  always_comb begin
    if (in_zone) begin
      value = '0;
    end else if (centred > 9'sd127) begin
      value = 8'sd127;
    end else if (centred < -9'sd127) begin
      value = -8'sd127;
    end else begin
      value = centred[7:0];
    end
  end

endmodule

FILE: hdl/mwm_wheel.sv
// Clamps one wheel value and turns it into a direction bit and an even duty.
module mwm_wheel (
  input  logic signed [mwm_pkg::WHEEL_W-1:0] wheel,
  output logic                               dir,
  output logic [7:0]                         duty
);

  logic signed [mwm_pkg::WHEEL_W-1:0] clamped;
  logic signed [mwm_pkg::WHEEL_W-1:0] level;

  // Limit to +-127 in Q.8.
  always_comb begin
    if (wheel > mwm_pkg::WHEEL_LIMIT_Q8) begin
      clamped = mwm_pkg::WHEEL_LIMIT_Q8;
    end else if (wheel < -mwm_pkg::WHEEL_LIMIT_Q8) begin
      clamped = -mwm_pkg::WHEEL_LIMIT_Q8;
    end else begin
      clamped = wheel;
    end
  end

  // Negative drive is measured up from the lower limit; both cases are non-negative.
  assign dir   = clamped[mwm_pkg::WHEEL_W-1];
  assign level = dir ? (mwm_pkg::WHEEL_LIMIT_Q8 + clamped) : clamped;
  assign duty  = {level[14:8], 1'b0};

endmodule

FILE: hdl/mecanum_wheel_mixer.sv
// Top level of the mecanum wheel mixer: registers, pipeline and wheel outputs.
// An accepted request runs through v1_r, v2_r and out_valid_r in order to its result strobe.
// Throughput: one request per cycle; busy stays low, so start may be held high continuously.
// The three stages are input capture, centring with the three multipliers, and wheel mixing.
// Synchronous active-low reset clears the pipeline valid bits and restores
// deadband = 10 and turn gain = 1.0; the receiver cannot stall the result strobe.
module mecanum_wheel_mixer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [7:0]                      in_stick_x,
  input  logic [7:0]                      in_stick_y,
  input  logic [7:0]                      in_stick_turn,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mwm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  output logic                            out_dir_front_left,
  output logic                            out_dir_front_right,
  output logic                            out_dir_rear_left,
  output logic                            out_dir_rear_right,
  output logic [7:0]                      out_duty_front_left,
  output logic [7:0]                      out_duty_front_right,
  output logic [7:0]                      out_duty_rear_left,
  output logic [7:0]                      out_duty_rear_right
);

  logic [mwm_pkg::DEADBAND_W-1:0]  deadband_r;
  logic [mwm_pkg::TURN_GAIN_W-1:0] turn_gain_r;

  logic       v1_r;
  logic [7:0] x_raw_r;
  logic [7:0] y_raw_r;
  logic [7:0] t_raw_r;

  logic signed [mwm_pkg::AXIS_W-1:0] x_ax;
  logic signed [mwm_pkg::AXIS_W-1:0] y_ax;
  logic signed [mwm_pkg::AXIS_W-1:0] t_ax;
  logic signed [mwm_pkg::SUM_W-1:0]  sum_a;
  logic signed [mwm_pkg::SUM_W-1:0]  sum_b;
  logic signed [mwm_pkg::PROD_W-1:0] prod_a;
  logic signed [mwm_pkg::PROD_W-1:0] prod_b;
  logic signed [mwm_pkg::TURN_W-1:0] gain_s;
  logic signed [mwm_pkg::TURN_W-1:0] turn_prod;

  logic                              v2_r;
  logic signed [mwm_pkg::ROT_W-1:0]  a8_r;
  logic signed [mwm_pkg::ROT_W-1:0]  b8_r;
  logic signed [mwm_pkg::TURN_W-1:0] r8_r;

  logic signed [mwm_pkg::WHEEL_W-1:0] w_fl;
  logic signed [mwm_pkg::WHEEL_W-1:0] w_fr;
  logic signed [mwm_pkg::WHEEL_W-1:0] w_rl;
  logic signed [mwm_pkg::WHEEL_W-1:0] w_rr;
  logic                               dir_fl;
  logic                               dir_fr;
  logic                               dir_rl;
  logic                               dir_rr;
  logic [7:0]                         duty_fl;
  logic [7:0]                         duty_fr;
  logic [7:0]                         duty_rl;
  logic [7:0]                         duty_rr;

  logic       out_valid_r;
  logic [3:0] dir_r;
  logic [7:0] duty_fl_r;
  logic [7:0] duty_fr_r;
  logic [7:0] duty_rl_r;
  logic [7:0] duty_rr_r;

  // The pipeline takes a request every cycle and writes are always taken.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers; upper data bits beyond each register are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r  <= mwm_pkg::DEADBAND_RST;
      turn_gain_r <= mwm_pkg::TURN_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mwm_pkg::CFG_DEADBAND:  deadband_r  <= cfg_data[mwm_pkg::DEADBAND_W-1:0];
        mwm_pkg::CFG_TURN_GAIN: turn_gain_r <= cfg_data[mwm_pkg::TURN_GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage one: capture the request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      x_raw_r <= in_stick_x;
      y_raw_r <= in_stick_y;
      t_raw_r <= in_stick_turn;
    end
  end

  // Stage two: centre the axes, rotate the strafe vector and scale the turn.
  mwm_axis u_axis_x (.raw(x_raw_r), .invert(1'b0), .deadband(deadband_r), .value(x_ax));
  mwm_axis u_axis_y (.raw(y_raw_r), .invert(1'b1), .deadband(deadband_r), .value(y_ax));
  mwm_axis u_axis_t (.raw(t_raw_r), .invert(1'b1), .deadband(deadband_r), .value(t_ax));

  assign sum_a     = mwm_pkg::SUM_W'(y_ax) + mwm_pkg::SUM_W'(x_ax);
  assign sum_b     = mwm_pkg::SUM_W'(y_ax) - mwm_pkg::SUM_W'(x_ax);
  assign prod_a    = mwm_pkg::PROD_W'(sum_a) * mwm_pkg::INV_SQRT2_Q16;
  assign prod_b    = mwm_pkg::PROD_W'(sum_b) * mwm_pkg::INV_SQRT2_Q16;
  assign gain_s    = $signed({{(mwm_pkg::TURN_W-mwm_pkg::TURN_GAIN_W){1'b0}}, turn_gain_r});
  assign turn_prod = mwm_pkg::TURN_W'(t_ax) * gain_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  // Dropping eight fraction bits of a signed product rounds towards minus infinity.
  always_ff @(posedge clk) begin
    a8_r <= prod_a[mwm_pkg::PROD_W-1:8];
    b8_r <= prod_b[mwm_pkg::PROD_W-1:8];
    r8_r <= turn_prod;
  end

  // Stage three: mix each wheel and convert to direction and duty.
  assign w_fl = mwm_pkg::WHEEL_W'(a8_r) + mwm_pkg::WHEEL_W'(r8_r);
  assign w_fr = mwm_pkg::WHEEL_W'(b8_r) - mwm_pkg::WHEEL_W'(r8_r);
  assign w_rl = mwm_pkg::WHEEL_W'(b8_r) + mwm_pkg::WHEEL_W'(r8_r);
  assign w_rr = mwm_pkg::WHEEL_W'(a8_r) - mwm_pkg::WHEEL_W'(r8_r);

  mwm_wheel u_wheel_fl (.wheel(w_fl), .dir(dir_fl), .duty(duty_fl));
  mwm_wheel u_wheel_fr (.wheel(w_fr), .dir(dir_fr), .duty(duty_fr));
  mwm_wheel u_wheel_rl (.wheel(w_rl), .dir(dir_rl), .duty(duty_rl));
  mwm_wheel u_wheel_rr (.wheel(w_rr), .dir(dir_rr), .duty(duty_rr));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    dir_r     <= {dir_rr, dir_rl, dir_fr, dir_fl};
    duty_fl_r <= duty_fl;
    duty_fr_r <= duty_fr;
    duty_rl_r <= duty_rl;
    duty_rr_r <= duty_rr;
  end

  // Result ports.
  assign out_valid            = out_valid_r;
  assign out_dir_front_left   = dir_r[0];
  assign out_dir_front_right  = dir_r[1];
  assign out_dir_rear_left    = dir_r[2];
  assign out_dir_rear_right   = dir_r[3];
  assign out_duty_front_left  = duty_fl_r;
  assign out_duty_front_right = duty_fr_r;
  assign out_duty_rear_left   = duty_rl_r;
  assign out_duty_rear_right  = duty_rr_r;

  // Every accepted request yields a result strobe.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##3 out_valid)
    else $error("result strobe missing three cycles after a request");

  // Duties are always even.
  a_even_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_duty_front_left[0] == 1'b0) && (out_duty_front_right[0] == 1'b0)
               && (out_duty_rear_left[0] == 1'b0) && (out_duty_rear_right[0] == 1'b0))
    else $error("odd duty on result");

  // Negative drive never reaches full duty.
  a_neg_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_dir_front_left || out_duty_front_left != 8'd254)
               && (!out_dir_front_right || out_duty_front_right != 8'd254)
               && (!out_dir_rear_left || out_duty_rear_left != 8'd254)
               && (!out_dir_rear_right || out_duty_rear_right != 8'd254))
    else $error("negative drive with full duty");

  // No strobe without an earlier request.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##3 !out_valid)
    else $error("result strobe without a request");

endmodule
